### src/fxdt_pkg.sv
`timescale 1ns / 1ps
package fxdt_pkg;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CONV,
        B_SKIP,
        B_SIGN,
        B_INT,
        B_POINT,
        B_FRAC
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_POINT = 7'h2E;
    localparam logic [6:0] CH_ZERO  = 7'h30;

endpackage

### src/fxdt_queue.sv
`timescale 1ns / 1ps
module fxdt_queue #(
    parameter int WIDTH = 33
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output fxdt_pkg::t_q_status o_status
);
    import fxdt_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;
    logic             n_wr;
    logic             n_rd;
    logic [1:0]       n_count;

    always_comb begin
        n_wr    = i_push ? ~r_wr : r_wr;
        n_rd    = i_pop  ? ~r_rd : r_rd;
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

endmodule

### src/fxdt_front.sv
`timescale 1ns / 1ps
module fxdt_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     start,
    output logic                     busy,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  fxdt_pkg::t_q_status      i_status,
    output logic                     o_push,
    output logic [VALUE_WIDTH:0]     o_job
);
    import fxdt_pkg::*;

    logic                   neg;
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;

    // Magnitude in unsigned arithmetic: the most negative value maps onto itself,
    // which is exactly 2^(W-1) read unsigned.
    always_comb begin
        raw = VALUE_WIDTH'(i_value);
        neg = raw[VALUE_WIDTH-1];
        mag = neg ? (~raw + 1'b1) : raw;
    end

    assign busy   = i_status.full;
    assign o_push = start & ~i_status.full;
    assign o_job  = {neg, mag};

endmodule

### src/fxdt_back.sv
`timescale 1ns / 1ps
module fxdt_back #(
    parameter int VALUE_WIDTH     = 32,
    parameter int FRACTION_DIGITS = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fxdt_pkg::t_q_status  i_status,
    input  logic [VALUE_WIDTH:0] i_job,
    output logic                 o_pop,
    output logic                 o_strobe,
    output logic [6:0]           o_character,
    output logic                 o_last
);
    import fxdt_pkg::*;

    localparam int MAG_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int NUM_DIGITS = (MAG_DIGITS > FRACTION_DIGITS) ? MAG_DIGITS
                                                               : FRACTION_DIGITS + 1;
    localparam int BW = 4 * NUM_DIGITS;
    localparam int CW = $clog2(VALUE_WIDTH);
    localparam int RW = $clog2(NUM_DIGITS + 1);

    t_back_state            r_state;
    t_back_state            n_state;
    logic [VALUE_WIDTH-1:0] r_shift;
    logic [VALUE_WIDTH-1:0] n_shift;
    logic [BW-1:0]          r_bcd;
    logic [BW-1:0]          n_bcd;
    logic [CW-1:0]          r_cnt;
    logic [CW-1:0]          n_cnt;
    logic [RW-1:0]          r_rem;
    logic [RW-1:0]          n_rem;
    logic                   r_neg;
    logic                   n_neg;
    logic                   r_valid;
    logic                   n_valid;
    logic [6:0]             r_char;
    logic [6:0]             n_char;
    logic                   r_last;
    logic                   n_last;

    logic [BW-1:0]          adj;
    logic [3:0]             top;
    logic                   skip;

    assign top   = r_bcd[BW-1 -: 4];
    // leading zero of the integer part, keeping one integer digit
    assign skip  = (top == 4'd0) && (r_rem > RW'(FRACTION_DIGITS + 1));
    assign o_pop = (r_state == B_IDLE) && !i_status.empty;

    // double dabble correction, all digits in parallel
    always_comb begin
        logic [3:0] dig;
        dig = 4'd0;
        adj = r_bcd;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            dig = r_bcd[4*d +: 4];
            adj[4*d +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (!i_status.empty) n_state = B_CONV;
            B_CONV:  if (r_cnt == '0) n_state = B_SKIP;
            B_SKIP:  if (!skip) n_state = r_neg ? B_SIGN : B_INT;
            B_SIGN:  n_state = B_INT;
            B_INT:   if (r_rem == RW'(FRACTION_DIGITS + 1)) n_state = B_POINT;
            B_POINT: n_state = B_FRAC;
            B_FRAC:  if (r_rem == RW'(1)) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_shift = r_shift;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_neg   = r_neg;
        case (r_state)
            B_IDLE: begin
                n_shift = i_job[VALUE_WIDTH-1:0];
                n_neg   = i_job[VALUE_WIDTH];
                n_cnt   = CW'(VALUE_WIDTH - 1);
                n_bcd   = '0;
            end
            B_CONV: begin
                n_bcd   = {adj[BW-2:0], r_shift[VALUE_WIDTH-1]};
                n_shift = {r_shift[VALUE_WIDTH-2:0], 1'b0};
                n_cnt   = r_cnt - 1'b1;
                n_rem   = RW'(NUM_DIGITS);
            end
            B_SKIP: begin
                if (skip) begin
                    n_bcd = {r_bcd[BW-5:0], 4'd0};
                    n_rem = r_rem - 1'b1;
                end
            end
            B_INT, B_FRAC: begin
                n_bcd = {r_bcd[BW-5:0], 4'd0};
                n_rem = r_rem - 1'b1;
            end
            default: begin
                n_bcd = r_bcd;
            end
        endcase
    end

    // outputs
    always_comb begin
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = 1'b0;
        case (r_state)
            B_SIGN: begin
                n_valid = 1'b1;
                n_char  = CH_MINUS;
            end
            B_INT: begin
                n_valid = 1'b1;
                n_char  = CH_ZERO + {3'b000, top};
            end
            B_POINT: begin
                n_valid = 1'b1;
                n_char  = CH_POINT;
            end
            B_FRAC: begin
                n_valid = 1'b1;
                n_char  = CH_ZERO + {3'b000, top};
                n_last  = (r_rem == RW'(1));
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_neg   <= n_neg;
        r_char  <= n_char;
    end

    assign o_strobe    = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |=> !r_valid)
        else $error("character straight after last");
    a_quiet_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CONV) |=> !r_valid)
        else $error("character during conversion");
    a_frac_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FRAC) |-> (r_rem >= RW'(1) && r_rem <= RW'(FRACTION_DIGITS)))
        else $error("fraction digit count out of range");
    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last |-> r_valid)
        else $error("last flag without strobe");

endmodule

### src/fixed_point_to_decimal_text_core.sv
`timescale 1ns / 1ps
// Channel  Ports                           Handshake
// -------  ------------------------------  ----------------------------------
// input    i_value                         word taken when start & !busy
// result   o_character, o_last             word valid for one cycle on o_strobe
//
// Conversion of one word: fetch it from the queue, bit-serial binary to BCD over all
// VALUE_WIDTH bits, find the first integer digit stepping over each leading zero,
// then one character per cycle (8 to 12 characters at default sizes). Skipped
// zeros plus integer digits always fill the integer field.
// The two-entry queue takes further words while one converts; busy is high while full.
// Reset (i_rst_n low, synchronous) empties the queue and idles the converter.
// The receiver cannot stall: every strobed character is taken in its cycle.
module fixed_point_to_decimal_text_core #(
    parameter int FRACTION_DIGITS = 6,
    parameter int VALUE_WIDTH     = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_strobe,
    output logic [6:0]                    o_character,
    output logic                          o_last
);
    import fxdt_pkg::*;

    // queue word: sign bit above the magnitude
    logic                 push;
    logic                 pop;
    logic [VALUE_WIDTH:0] job_in;
    logic [VALUE_WIDTH:0] job_out;
    t_q_status            q_status;

    // front: sign split and magnitude
    fxdt_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .start    (start),
        .busy     (busy),
        .i_value  (i_value),
        .i_status (q_status),
        .o_push   (push),
        .o_job    (job_in)
    );

    fxdt_queue #(
        .WIDTH (VALUE_WIDTH + 1)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (job_in),
        .i_pop    (pop),
        .o_data   (job_out),
        .o_status (q_status)
    );

    // back: BCD conversion and character sequencing
    fxdt_back #(
        .VALUE_WIDTH     (VALUE_WIDTH),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_status    (q_status),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

### tb/fixed_point_to_decimal_text_checker.sv
`timescale 1ns / 1ps
module fixed_point_to_decimal_text_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_value,
    input  logic        i_strobe,
    input  logic [6:0]  i_character,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_chars_due
);
    import fxdt_pkg::*;

    localparam int          FRAC_DIGITS = 6;
    localparam logic [31:0] FRAC_SCALE  = 32'd1000000;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } glyph_t;

    glyph_t text_due[$];
    glyph_t due_glyph;
    int     fail_tally;
    logic   field_bad;

    // Sign, then integer part of the magnitude, point, zero-padded fraction.
    function automatic void queue_text(input logic [31:0] raw);
        logic [31:0] mag;
        logic [31:0] whole;
        logic [31:0] frac;
        logic [3:0]  int_digit[$];
        logic [3:0]  frac_digit[FRAC_DIGITS];
        mag   = raw[31] ? (~raw + 32'd1) : raw;
        whole = mag / FRAC_SCALE;
        frac  = mag % FRAC_SCALE;
        if (raw[31]) begin
            text_due.push_back(glyph_t'{CH_MINUS, 1'b0});
        end
        do begin
            int_digit.push_front(4'(whole % 10));
            whole = whole / 10;
        end while (whole != 0);
        foreach (int_digit[k]) begin
            text_due.push_back(glyph_t'{CH_ZERO + {3'b000, int_digit[k]}, 1'b0});
        end
        text_due.push_back(glyph_t'{CH_POINT, 1'b0});
        for (int k = 0; k < FRAC_DIGITS; k++) begin
            frac_digit[k] = 4'(frac % 10);
            frac          = frac / 10;
        end
        for (int k = FRAC_DIGITS - 1; k >= 0; k--) begin
            text_due.push_back(glyph_t'{CH_ZERO + {3'b000, frac_digit[k]}, k == 0});
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            text_due.delete();
            fail_tally = 0;
        end else begin
            // strobed character first: it can never belong to a word taken this edge
            if (i_strobe) begin
                if (text_due.size() == 0) begin
                    $display("%0t: character %h last %b with nothing expected",
                             $time, i_character, i_last);
                    fail_tally++;
                end else begin
                    due_glyph = text_due.pop_front();
                    field_bad = 1'b0;
                    if (i_character !== due_glyph.code) begin
                        $display("%0t: character expected %h got %h",
                                 $time, due_glyph.code, i_character);
                        field_bad = 1'b1;
                    end
                    if (i_last !== due_glyph.last) begin
                        $display("%0t: last expected %b got %b",
                                 $time, due_glyph.last, i_last);
                        field_bad = 1'b1;
                    end
                    if (field_bad) fail_tally++;
                end
            end
            if (i_start && !i_busy) queue_text(i_value);
        end
        o_fail_count <= fail_tally;
        o_chars_due  <= text_due.size();
    end

endmodule

### tb/tb_fixed_point_to_decimal_text_core.sv
`timescale 1ns / 1ps
// Stimulus and verdict only; the checker beside the block predicts the text
// of every word taken and compares each strobed character against it.
module tb_fixed_point_to_decimal_text_core;
    import fxdt_pkg::*;

    // quiet cycles allowed; sender gaps are short
    localparam int QUIET_LIMIT  = 4000;
    // settle time after the last expected character, roughly one conversion
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_WORDS  = 120;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_value;
    logic               o_strobe;
    logic [6:0]         o_character;
    logic               o_last;

    int fail_count;
    int chars_due;
    int quiet_cycles;

    // corner words: zero, one millionth each way, the sub-one negatives that
    // must keep their sign, exact integers, both ends of the range (the most
    // negative word has no positive twin), and alternating bit patterns
    int corner_words[20] = '{
        0, 1, -1, -5, 999999, -999999, 1000000, -1000000, 1000001, 10000000,
        -2000000, 2147483647, 32'h8000_0000, 32'h8000_0001, 123456789,
        -123456789, 32'h5555_5555, 32'hAAAA_AAAA, 100000, -10
    };

    fixed_point_to_decimal_text_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

    fixed_point_to_decimal_text_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_value      (i_value),
        .i_strobe     (o_strobe),
        .i_character  (o_character),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_chars_due  (chars_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: any taken input word or strobed character counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("fixed_point_to_decimal_text_core regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Mix of shapes: full-range noise, values near zero (sign with a zero
    // integer part), exact integers, integer plus a tiny fraction, and the
    // words right at either end of the range.
    function automatic int pick_value();
        int shape;
        int mag;
        shape = $urandom_range(9);
        case (shape)
            0, 1, 2, 3: return int'($urandom);
            4, 5:       return int'($urandom_range(4000000)) - 2000000;
            6:          mag = int'($urandom_range(2147)) * 1000000;
            7:          mag = int'($urandom_range(999999));
            8: begin
                if ($urandom_range(1)) return 32'h8000_0000 + int'($urandom_range(3));
                return 32'h7FFF_FFFF - int'($urandom_range(3));
            end
            default:    mag = int'($urandom_range(2146)) * 1000000
                              + int'($urandom_range(99));
        endcase
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // Offer one word and hold it until taken. Before it, start drops for a
    // random run of idle cycles; with no gap it simply stays high.
    task automatic offer_word(input int word, input int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start   <= 1'b1;
        i_value <= word;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic run_phase(input int count, input int idle_pct);
        repeat (count) offer_word(pick_value(), idle_pct);
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_value = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_words[k]) offer_word(corner_words[k], 0);

        // back to back, heavy sender idling, light idling, then back to back
        run_phase(PHASE_WORDS, 0);
        run_phase(PHASE_WORDS, 87);
        run_phase(PHASE_WORDS, 8);
        run_phase(PHASE_WORDS, 0);
        start <= 1'b0;

        // drain: the checker's count is registered and lags, so always step at least once
        do @(posedge i_clk); while (chars_due != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("fixed_point_to_decimal_text_core regression: pass");
        end else begin
            $display("fixed_point_to_decimal_text_core regression: fail");
        end
        $finish;
    end

endmodule
